// ===== rtl/kdsl_pkg.sv =====
package kdsl_pkg;

   localparam int NUM_KEYS_DEF   = 4;
   localparam int TICK_WIDTH_DEF = 32;
   localparam int MASK_WIDTH     = 4;
   localparam int EVENT_WIDTH    = 2;
   localparam int INTERVAL_WIDTH = 8;
   localparam int LONG_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [INTERVAL_WIDTH-1:0] SAMPLE_INTERVAL_RESET = 8'd20;
   localparam logic [LONG_WIDTH-1:0]     LONG_PRESS_RESET      = 16'd1000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_INTERVAL = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS      = 1'b1;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_NONE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   typedef struct packed {
      event_type key_event;
      logic      beep_set;
      logic      beep_clr;
   } key_status_type;

endpackage

// ===== rtl/kdsl_timer.sv =====
module kdsl_timer #(
   parameter int TickWidth = kdsl_pkg::TICK_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [kdsl_pkg::INTERVAL_WIDTH-1:0]  sample_interval,
   output logic [TickWidth-1:0]                 tick_next,
   output logic                                 sample
);
   import kdsl_pkg::*;

   logic [TickWidth-1:0] tick_ff;
   logic [TickWidth-1:0] last_ff;
   logic [TickWidth-1:0] since_last;
   logic                 interval_one;

   assign tick_next    = tick_ff + TickWidth'(1);
   assign since_last   = tick_next - last_ff;
   assign interval_one = (sample_interval == INTERVAL_WIDTH'(1));
   assign sample       = interval_one || (since_last >= TickWidth'(sample_interval));

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         last_ff <= '0;
      end else if (step) begin
         tick_ff <= tick_next;
         if (sample && !interval_one) begin
            last_ff <= tick_next;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(tick_ff) && $stable(last_ff))
      else $error("tick state moved without a word");

endmodule

// ===== rtl/kdsl_key.sv =====
module kdsl_key #(
   parameter int TickWidth = kdsl_pkg::TICK_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             down,
   input  logic [TickWidth-1:0]             tick,
   input  logic [kdsl_pkg::LONG_WIDTH-1:0]  long_press_ticks,
   output kdsl_pkg::key_status_type         status
);
   import kdsl_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DEBOUNCE,
      MODE_SHORT,
      MODE_LONG
   } mode_type;

   mode_type             mode_ff;
   mode_type             mode_in;
   logic [TickWidth-1:0] start_ff;
   logic [TickWidth-1:0] start_in;
   logic [TickWidth-1:0] held;
   logic                 long_hit;

   assign held     = tick - start_ff;
   assign long_hit = held > TickWidth'(long_press_ticks);

   always_comb begin
      mode_in          = mode_ff;
      start_in         = start_ff;
      status.key_event = EV_NONE;
      status.beep_set  = 1'b0;
      status.beep_clr  = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (down) begin
               start_in = tick;
               mode_in  = MODE_DEBOUNCE;
            end
         end
         MODE_DEBOUNCE: begin
            if (down) begin
               start_in        = tick;
               mode_in         = MODE_SHORT;
               status.beep_set = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_SHORT: begin
            status.beep_clr = 1'b1;
            if (down) begin
               if (long_hit) begin
                  start_in = tick;
                  mode_in  = MODE_LONG;
               end
            end else begin
               status.key_event = EV_CLICK;
               mode_in          = MODE_IDLE;
            end
         end
         MODE_LONG: begin
            if (!down) begin
               status.key_event = EV_LONG;
               mode_in          = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (enable) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(mode_ff))
      else $error("key mode moved without a sample");

   assert property (@(posedge clock) disable iff (reset)
      enable && mode_ff == MODE_LONG && !down |=> mode_ff == MODE_IDLE)
      else $error("release from long press did not return to idle");

endmodule

// ===== rtl/key_debounce_short_long_press.sv =====
// Four-key debounce with single-click and long-press detection.
// Input channel req_: one word per system tick, req_pressed_mask holds the
// pressed keys (bit0 back, bit1 right, bit2 left, bit3 ok). A word is taken
// at an edge with req_valid high and req_stall low.
// Result channel rsp_: one word for every input word, in order: the sample
// flag, one event per key (none, single click, long press), the beeper level
// and the last non-empty sampled key mask.
// A word taken into the input register moves on to the result register and rsp_.
// Throughput: one word per cycle while not stalled; the tick counter steps on
// each word, key machines on sampled words, in one pass between the registers.
// While rsp_stall holds a valid result word, one more word waits in the input
// register, after which req_stall goes high until the result moves.
// Registers via csr_: index 0 sample interval, index 1 long-press ticks;
// write only while no word is in flight.
// Reset (synchronous) clears the tick counter, all keys to idle, the beeper,
// the held mask and the valid flags of both channel registers, and loads the
// interval with 20 and the long-press time with 1000.
module key_debounce_short_long_press #(
   parameter int NumKeys   = kdsl_pkg::NUM_KEYS_DEF,
   parameter int TickWidth = kdsl_pkg::TICK_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [kdsl_pkg::MASK_WIDTH-1:0]       req_pressed_mask,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_sampled,
   output logic [kdsl_pkg::EVENT_WIDTH-1:0]      rsp_back_event,
   output logic [kdsl_pkg::EVENT_WIDTH-1:0]      rsp_right_event,
   output logic [kdsl_pkg::EVENT_WIDTH-1:0]      rsp_left_event,
   output logic [kdsl_pkg::EVENT_WIDTH-1:0]      rsp_ok_event,
   output logic                                  rsp_beep_on,
   output logic [kdsl_pkg::MASK_WIDTH-1:0]       rsp_held_keys,
   input  logic                                  csr_write_en,
   input  logic [kdsl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kdsl_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import kdsl_pkg::*;

   logic [INTERVAL_WIDTH-1:0] interval_ff;
   logic [LONG_WIDTH-1:0]     long_ff;

   logic                  in_valid_ff;
   logic [MASK_WIDTH-1:0] in_mask_ff;
   logic                  advance;
   logic                  req_take;

   logic                  sample;
   logic                  step_sample;
   logic [TickWidth-1:0]  tick_next;

   key_status_type        key_status [NumKeys];
   event_type             ev_word [MASK_WIDTH];

   logic                  beep_ff;
   logic                  beep_in;
   logic                  beep_mix;
   logic [MASK_WIDTH-1:0] held_ff;
   logic [MASK_WIDTH-1:0] held_in;

   logic                  rsp_valid_ff;
   logic                  rsp_sampled_ff;
   event_type             rsp_event_ff [MASK_WIDTH];
   logic                  rsp_beep_ff;
   logic [MASK_WIDTH-1:0] rsp_held_ff;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign step_sample = advance && sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= SAMPLE_INTERVAL_RESET;
         long_ff     <= LONG_PRESS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_ff <= csr_wdata[INTERVAL_WIDTH-1:0];
            CSR_LONG_PRESS:      long_ff     <= csr_wdata[LONG_WIDTH-1:0];
            default:             ;
         endcase
      end
   end

   kdsl_timer #(.TickWidth(TickWidth)) u_timer (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .sample_interval (interval_ff),
      .tick_next       (tick_next),
      .sample          (sample)
   );

   for (genvar k = 0; k < NumKeys; k++) begin : g_key
      logic down;
      if (k < MASK_WIDTH) begin : g_wired
         assign down = in_mask_ff[k];
      end else begin : g_unwired
         assign down = 1'b0;
      end
      kdsl_key #(.TickWidth(TickWidth)) u_key (
         .clock            (clock),
         .reset            (reset),
         .enable           (step_sample),
         .down             (down),
         .tick             (tick_next),
         .long_press_ticks (long_ff),
         .status           (key_status[k])
      );
   end

   for (genvar k = 0; k < MASK_WIDTH; k++) begin : g_event
      if (k < NumKeys) begin : g_live
         assign ev_word[k] = sample ? key_status[k].key_event : EV_NONE;
      end else begin : g_absent
         assign ev_word[k] = EV_NONE;
      end
   end

   // later keys override earlier ones
   always_comb begin
      beep_mix = beep_ff;
      for (int k = 0; k < NumKeys; k++) begin
         if (key_status[k].beep_set) begin
            beep_mix = 1'b1;
         end else if (key_status[k].beep_clr) begin
            beep_mix = 1'b0;
         end
      end
   end

   assign beep_in = sample ? beep_mix : beep_ff;
   assign held_in = (sample && in_mask_ff != '0) ? in_mask_ff : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         beep_ff      <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            beep_ff      <= beep_in;
            held_ff      <= held_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mask_ff <= req_pressed_mask;
      end
      if (advance) begin
         rsp_sampled_ff <= sample;
         rsp_event_ff   <= ev_word;
         rsp_beep_ff    <= beep_in;
         rsp_held_ff    <= held_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sampled     = rsp_sampled_ff;
   assign rsp_back_event  = rsp_event_ff[0];
   assign rsp_right_event = rsp_event_ff[1];
   assign rsp_left_event  = rsp_event_ff[2];
   assign rsp_ok_event    = rsp_event_ff[3];
   assign rsp_beep_on     = rsp_beep_ff;
   assign rsp_held_keys   = rsp_held_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sampled |-> rsp_back_event == EV_NONE && rsp_right_event == EV_NONE
         && rsp_left_event == EV_NONE && rsp_ok_event == EV_NONE)
      else $error("key event reported without a sample");

   assert property (@(posedge clock) disable iff (reset)
      !step_sample |=> $stable(beep_ff) && $stable(held_ff))
      else $error("beeper or held mask moved without a sample");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_beep_ff == beep_ff && rsp_held_ff == held_ff)
      else $error("result word disagrees with held state");

endmodule
